FILE: design/sll_pkg.sv
package sll_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 6;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_CHANGE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_LOCATE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD_POS   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic                     clear;
        logic                     shift;
        logic                     locate;
        logic                     ins;
        logic                     del;
        logic                     wr;
        logic signed [DATA_W-1:0] ix;
        logic signed [DATA_W-1:0] iy;
    } sll_ctrl_t;

    // Result token that moves toward cell 0 one cell per cycle while the sequencer scans.
    typedef struct packed {
        logic                     hit;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } sll_tok_t;

endpackage

FILE: design/static_linked_list_engine_top.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | opcode, position, item_x, item_y
// out     | output    | out_valid/out_ready | status, found_position, old_x, old_y,
//         |           |                     | list_length
//
// Each item passes IDLE, SCAN and DONE on its way to a registered result: the
// accepting edge clears the result tokens, SCAN moves them down the row
// of element cells, and DONE updates the cells and loads the output register.
// The next item is accepted only back in IDLE, once the last one is done.
// The list lives in order in the cell row; reset empties it at once.
// A result waiting in the output register holds the update cycle of the next item.
module static_linked_list_engine_top
    import sll_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               opcode,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] item_x,
    input  logic signed [DATA_W-1:0] item_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [POS_W-1:0]         found_position,
    output logic signed [DATA_W-1:0] old_x,
    output logic signed [DATA_W-1:0] old_y,
    output logic [POS_W-1:0]         list_length
);

    localparam int NCELL = SLOTS - 2;
    localparam int CW    = $clog2(SLOTS);
    localparam int CMPW  = (CW + 1 > POS_W) ? CW + 1 : POS_W;

    typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            scan_reg, scan_next;
    logic [2:0]               op_reg, op_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] ix_reg, ix_next, iy_reg, iy_next;

    logic                     ov_reg, ov_next;
    logic [1:0]               st_reg, st_next;
    logic [POS_W-1:0]         fp_reg, fp_next;
    logic signed [DATA_W-1:0] ox_reg, ox_next, oy_reg, oy_next;

    sll_ctrl_t                ctrl;
    sll_tok_t                 tok [NCELL+1];
    logic signed [DATA_W-1:0] cx [NCELL];
    logic signed [DATA_W-1:0] cy [NCELL];
    logic [CW-1:0]            k;
    logic [CMPW-1:0]          pos_c, cnt_c;
    logic                     go;

    assign in_ready = state_reg == IDLE;
    assign pos_c    = CMPW'(pos_reg);
    assign cnt_c    = CMPW'(cnt_reg);
    assign k        = CW'(pos_reg - POS_W'(1));
    assign go       = state_reg == DONE && (!ov_reg || out_ready);
    assign tok[NCELL] = '0;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        scan_next  = scan_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        fp_next    = fp_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;

        ctrl        = '0;
        ctrl.ix     = ix_reg;
        ctrl.iy     = iy_reg;
        ctrl.locate = op_reg == OP_LOCATE;

        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    pos_next   = position;
                    ix_next    = item_x;
                    iy_next    = item_y;
                    scan_next  = '0;
                    ctrl.clear = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                ctrl.shift = 1'b1;
                scan_next  = scan_reg + CW'(1);
                if (scan_reg == CW'(NCELL - 1))
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (go)
                begin
                    ov_next = 1'b1;
                    st_next = ST_OK;
                    fp_next = '0;
                    ox_next = '0;
                    oy_next = '0;
                    case (op_reg) inside
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(NCELL))
                                st_next = ST_FULL_EMPTY;
                            else if (pos_c == '0 || pos_c > cnt_c + CMPW'(1))
                                st_next = ST_BAD_POS;
                            else
                            begin
                                ctrl.ins = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_DELETE, OP_CHANGE, OP_READ:
                        begin
                            if (cnt_reg == '0)
                                st_next = ST_FULL_EMPTY;
                            else if (pos_c == '0 || pos_c > cnt_c)
                                st_next = ST_BAD_POS;
                            else
                            begin
                                ox_next = tok[0].x;
                                oy_next = tok[0].y;
                                if (op_reg == OP_DELETE)
                                begin
                                    ctrl.del = 1'b1;
                                    cnt_next = cnt_reg - CW'(1);
                                end
                                else if (op_reg == OP_CHANGE)
                                begin
                                    ctrl.wr = 1'b1;
                                end
                            end
                        end
                        OP_LOCATE:
                        begin
                            if (cnt_reg == '0)
                                st_next = ST_FULL_EMPTY;
                            else if (tok[0].hit)
                                fp_next = tok[0].pos;
                            else
                                st_next = ST_NOT_FOUND;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            scan_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            scan_reg  <= scan_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        pos_reg <= pos_next;
        ix_reg  <= ix_next;
        iy_reg  <= iy_next;
        st_reg  <= st_next;
        fp_reg  <= fp_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
    end

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        sll_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .k       (k),
            .count   (cnt_reg),
            .left_x  ((i == 0) ? cx[0] : cx[(i == 0) ? 0 : i-1]),
            .left_y  ((i == 0) ? cy[0] : cy[(i == 0) ? 0 : i-1]),
            .right_x (cx[(i == NCELL-1) ? i : i+1]),
            .right_y (cy[(i == NCELL-1) ? i : i+1]),
            .tok_in  (tok[i+1]),
            .tok_out (tok[i]),
            .x       (cx[i]),
            .y       (cy[i])
        );
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign found_position = fp_reg;
    assign old_x          = ox_reg;
    assign old_y          = oy_reg;
    assign list_length    = POS_W'(cnt_reg);

endmodule

FILE: design/sll_cell.sv
module sll_cell
    import sll_pkg::*;
#(
    parameter int CW  = 6,
    parameter int IDX = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sll_ctrl_t                ctrl,
    input  logic [CW-1:0]            k,
    input  logic [CW-1:0]            count,
    input  logic signed [DATA_W-1:0] left_x,
    input  logic signed [DATA_W-1:0] left_y,
    input  logic signed [DATA_W-1:0] right_x,
    input  logic signed [DATA_W-1:0] right_y,
    input  sll_tok_t                 tok_in,
    output sll_tok_t                 tok_out,
    output logic signed [DATA_W-1:0] x,
    output logic signed [DATA_W-1:0] y
);

    localparam logic [CW-1:0]    MY_IDX = CW'(IDX);
    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX + 1);

    logic signed [DATA_W-1:0] x_reg, x_next, y_reg, y_next;
    sll_tok_t                 tok_reg, tok_next;
    logic                     in_list, sel, hit;

    always_comb
    begin
        in_list = MY_IDX < count;
        sel     = MY_IDX == k;
        hit     = in_list && (ctrl.locate ? (x_reg == ctrl.ix && y_reg == ctrl.iy) : sel);

        tok_next = tok_reg;
        if (ctrl.clear)
        begin
            tok_next = '0;
        end
        else if (ctrl.shift)
        begin
            tok_next = hit ? sll_tok_t'{hit: 1'b1, pos: MY_POS, x: x_reg, y: y_reg} : tok_in;
        end

        x_next = x_reg;
        y_next = y_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX > k)
            begin
                x_next = left_x;
                y_next = left_y;
            end
            else if (sel)
            begin
                x_next = ctrl.ix;
                y_next = ctrl.iy;
            end
        end
        else if (ctrl.del)
        begin
            if (MY_IDX >= k)
            begin
                x_next = right_x;
                y_next = right_y;
            end
        end
        else if (ctrl.wr && sel)
        begin
            x_next = ctrl.ix;
            y_next = ctrl.iy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign tok_out = tok_reg;
    assign x       = x_reg;
    assign y       = y_reg;

endmodule

FILE: design/sll_checker.sv
module sll_checker
    import sll_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               status,
    input logic [POS_W-1:0]         found_position,
    input logic signed [DATA_W-1:0] old_x,
    input logic signed [DATA_W-1:0] old_y,
    input logic [POS_W-1:0]         list_length
);

    // The result register must hold while the consumer stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(old_x)
            && $stable(old_y) && $stable(list_length))
        else $error("result changed while stalled");

    // One item at a time: the block is busy right after taking an item.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted an item while busy");

    // A position is reported only with a good status.
    a_fpos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_position != '0 |-> status == ST_OK)
        else $error("position reported with an error status");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(list_length) <= SLOTS - 2)
        else $error("list length beyond capacity");

endmodule

bind static_linked_list_engine_top sll_checker #(.SLOTS(SLOTS)) u_sll_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .old_x          (old_x),
    .old_y          (old_y),
    .list_length    (list_length)
);

FILE: dv/static_linked_list_engine_top_tb.sv
module static_linked_list_engine_top_tb;
    import sll_pkg::*;

    localparam int NSLOT     = SLOTS_DEFAULT;
    localparam int MAX_LEN   = NSLOT - 2;
    localparam int N_RANDOM  = 2000;
    localparam int WD_LIMIT  = 20000;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  pos;
        logic [31:0] x;
        logic [31:0] y;
    } op_item_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [5:0]  fpos;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [5:0]  len;
    } op_result_t;

    typedef struct {
        op_item_t   item;
        bit         typed;
        op_result_t res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [5:0]  position;
    logic signed [31:0] item_x;
    logic signed [31:0] item_y;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
    logic [5:0]  list_length;

    static_linked_list_engine_top #(.SLOTS(NSLOT)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .position(position), .item_x(item_x), .item_y(item_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found_position(found_position),
        .old_x(old_x), .old_y(old_y), .list_length(list_length)
    );

    // The list is predicted as an ordered array; slot layout is not observable.
    logic [31:0] list_x [$];
    logic [31:0] list_y [$];
    op_result_t  pending_results [$];
    op_result_t  typed_results [$];
    bit          typed_flags [$];

    int  mismatches;
    int  results_seen;
    int  wd_count;
    int  items_sent;
    bit  calm;
    bit  timed_out;
    int  op_hits [8];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic op_result_t predict_list_op(op_item_t it);
        op_result_t r;
        int n;
        r = '{default: '0};
        n = list_x.size();
        case (it.op)
            OP_INSERT:
                if (n == MAX_LEN) r.st = ST_FULL_EMPTY;
                else if (it.pos == 0 || it.pos > n + 1) r.st = ST_BAD_POS;
                else
                begin
                    list_x.insert(it.pos - 1, it.x);
                    list_y.insert(it.pos - 1, it.y);
                end
            OP_DELETE, OP_CHANGE, OP_READ:
                if (n == 0) r.st = ST_FULL_EMPTY;
                else if (it.pos == 0 || it.pos > n) r.st = ST_BAD_POS;
                else
                begin
                    r.ox = list_x[it.pos - 1];
                    r.oy = list_y[it.pos - 1];
                    if (it.op == OP_DELETE)
                    begin
                        list_x.delete(it.pos - 1);
                        list_y.delete(it.pos - 1);
                    end
                    else if (it.op == OP_CHANGE)
                    begin
                        list_x[it.pos - 1] = it.x;
                        list_y[it.pos - 1] = it.y;
                    end
                end
            OP_LOCATE:
                if (n == 0) r.st = ST_FULL_EMPTY;
                else
                begin
                    r.st = ST_NOT_FOUND;
                    for (int i = 0; i < n; i++)
                    begin
                        if (list_x[i] == it.x && list_y[i] == it.y)
                        begin
                            r.st = ST_OK;
                            r.fpos = 6'(i + 1);
                            break;
                        end
                    end
                end
            OP_CLEAR:
            begin
                list_x.delete();
                list_y.delete();
            end
            default: ;
        endcase
        r.len = 6'(list_x.size());
        return r;
    endfunction

    // The valid line stays high from one item to the next unless an idle burst drops it.
    task automatic send_item(op_item_t it, bit typed, op_result_t tr, bit may_idle);
        op_result_t p;
        int gap;
        if (may_idle && !calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= it.op;
        position <= it.pos;
        item_x   <= it.x;
        item_y   <= it.y;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = predict_list_op(it);
        pending_results.push_back(p);
        typed_flags.push_back(typed);
        typed_results.push_back(tr);
        op_hits[it.op]++;
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out) @(posedge clk);
    endtask

    // Picks an op, a position and a pair: often a pair already on the list, so locates and duplicates hit.
    function automatic op_item_t random_item(int mode);
        op_item_t it;
        int n;
        int k;
        n = list_x.size();
        it.op = (mode == 0) ? 3'($urandom_range(0, 7)) : 3'(mode - 1);
        if (mode == 0 && $urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, 99);
            it.op = (k < 40) ? OP_INSERT : (k < 55) ? OP_DELETE : (k < 68) ? OP_CHANGE :
                    (k < 82) ? OP_READ : (k < 97) ? OP_LOCATE : OP_CLEAR;
        end
        if ($urandom_range(0, 9) == 0) it.pos = 6'($urandom_range(0, 63));
        else it.pos = 6'($urandom_range(1, (it.op == OP_INSERT) ? n + 1 : (n == 0 ? 1 : n)));
        case ($urandom_range(0, 3))
            0: begin it.x = $urandom_range(0, 3); it.y = $urandom_range(0, 3); end
            1: if (n > 0)
               begin
                   k = $urandom_range(0, n - 1);
                   it.x = list_x[k];
                   it.y = list_y[k];
               end
               else begin it.x = $urandom(); it.y = $urandom(); end
            default: begin it.x = $urandom(); it.y = $urandom(); end
        endcase
        return it;
    endfunction

    always @(posedge clk)
    begin
        op_result_t e;
        bit is_typed;
        op_result_t tr;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result with nothing pending");
            end
            else
            begin
                e = pending_results.pop_front();
                is_typed = typed_flags.pop_front();
                tr = typed_results.pop_front();
                if (is_typed && tr != e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row disagrees with predictor: %p vs %p", tr, e);
                end
                if (status !== e.st || found_position !== e.fpos || old_x !== e.ox ||
                    old_y !== e.oy || list_length !== e.len)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d fpos=%0d x=%h y=%h len=%0d, ",
                                 e.st, e.fpos, e.ox, e.oy, e.len,
                                 "got st=%0d fpos=%0d x=%h y=%h len=%0d",
                                 status, found_position, old_x, old_y, list_length);
                end
            end
        end
    end

    // Consumer side: random stall bursts until the calm tail.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) wd_count <= 0;
        else wd_count <= wd_count + 1;
    end

    always @(posedge clk)
    begin
        if (wd_count >= WD_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired after %0d idle cycles", wd_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    table_row_t directed [$];

    function automatic table_row_t row(logic [2:0] op, logic [5:0] pos, logic [31:0] x,
                                       logic [31:0] y, bit typed, logic [1:0] st,
                                       logic [5:0] fpos, logic [31:0] ox, logic [31:0] oy,
                                       logic [5:0] len);
        table_row_t t;
        t.item = '{op, pos, x, y};
        t.typed = typed;
        t.res = '{st, fpos, ox, oy, len};
        return t;
    endfunction

    initial
    begin
        op_item_t it;
        op_result_t none;
        none = '{default: '0};
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        calm = 1'b0;
        timed_out = 1'b0;
        wd_count = 0;
        in_valid = 1'b0;
        opcode = '0;
        position = '0;
        item_x = '0;
        item_y = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-list errors, bad positions, extremes of the pair, each op on a short list, unused opcodes.
        directed.push_back(row(OP_DELETE, 1, 0, 0, 1, ST_FULL_EMPTY, 0, 0, 0, 0));
        directed.push_back(row(OP_READ, 1, 0, 0, 1, ST_FULL_EMPTY, 0, 0, 0, 0));
        directed.push_back(row(OP_CHANGE, 1, 0, 0, 1, ST_FULL_EMPTY, 0, 0, 0, 0));
        directed.push_back(row(OP_LOCATE, 0, 0, 0, 1, ST_FULL_EMPTY, 0, 0, 0, 0));
        directed.push_back(row(OP_INSERT, 0, 0, 0, 1, ST_BAD_POS, 0, 0, 0, 0));
        directed.push_back(row(OP_INSERT, 2, 0, 0, 1, ST_BAD_POS, 0, 0, 0, 0));
        directed.push_back(row(OP_INSERT, 1, 32'h8000_0000, 32'h7fff_ffff, 1,
                               ST_OK, 0, 0, 0, 1));
        directed.push_back(row(OP_INSERT, 1, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_INSERT, 3, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_READ, 1, 0, 0, 1, ST_OK, 0, 32'hffff_ffff, 0, 3));
        directed.push_back(row(OP_READ, 0, 0, 0, 1, ST_BAD_POS, 0, 0, 0, 3));
        directed.push_back(row(OP_READ, 4, 0, 0, 1, ST_BAD_POS, 0, 0, 0, 3));
        directed.push_back(row(OP_LOCATE, 0, 32'h7fff_ffff, 32'h8000_0000, 1,
                               ST_OK, 3, 0, 0, 3));
        directed.push_back(row(OP_LOCATE, 0, 1, 1, 1, ST_NOT_FOUND, 0, 0, 0, 3));
        directed.push_back(row(OP_CHANGE, 2, 5, 6, 1, ST_OK, 0,
                               32'h8000_0000, 32'h7fff_ffff, 3));
        directed.push_back(row(OP_DELETE, 3, 0, 0, 1, ST_OK, 0,
                               32'h7fff_ffff, 32'h8000_0000, 2));
        directed.push_back(row(OP_DELETE, 63, 0, 0, 1, ST_BAD_POS, 0, 0, 0, 2));
        directed.push_back(row(3'd6, 1, 32'hffff_ffff, 32'hffff_ffff, 1, ST_OK, 0, 0, 0, 2));
        directed.push_back(row(3'd7, 63, 0, 0, 1, ST_OK, 0, 0, 0, 2));
        directed.push_back(row(OP_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].res, 1'b1);

        // Fill to capacity so the full case and position 62 are reached.
        for (int i = 0; i < MAX_LEN; i++)
        begin
            it = '{OP_INSERT, 6'(i + 1), $urandom(), $urandom()};
            send_item(it, 1'b0, none, 1'b1);
        end
        send_item('{OP_INSERT, 1, 0, 0}, 1'b1, '{ST_FULL_EMPTY, 0, 0, 0, 6'(MAX_LEN)}, 1'b1);
        send_item('{OP_READ, 6'(MAX_LEN), 0, 0}, 1'b0, none, 1'b1);
        it = '{OP_LOCATE, 0, list_x[MAX_LEN - 1], list_y[MAX_LEN - 1]};
        send_item(it, 1'b0, none, 1'b1);

        // Hold the sender until the engine has drained.
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 200) calm = 1'b1;
            send_item(random_item(0), 1'b0, none, 1'b1);
        end

        wait_drained();
        repeat (4 * NSLOT) @(posedge clk);
        $display("%0d items sent, %0d results checked", items_sent, results_seen);
        $display("ops ins/del/chg/read/loc/clr/unused: %0d %0d %0d %0d %0d %0d %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
                 op_hits[6] + op_hits[7]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
